FILE: hw/rtl/grs_pkg.sv
// grs_pkg: shared command codes and controller/datapath link types
// for the grid ray stepper. No dependencies.
package grs_pkg;

	// Command codes carried on the cmd field
	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_EXTEND = 3'd1,
		CMD_STEP   = 3'd2,
		CMD_UNIT   = 3'd3,
		CMD_TILE   = 3'd4,
		CMD_LOAD   = 3'd5
	} cmd_t;

	// Configuration register indexes
	localparam logic CFG_TILE_SHIFT = 1'b0;
	localparam logic CFG_STEP_LIMIT = 1'b1;

	localparam logic [3:0]  TILE_SHIFT_RST = 4'd3;
	localparam logic [15:0] STEP_LIMIT_RST = 16'd4096;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;   // input beat taken this cycle
		logic step_en;  // add the offset to the current point
		logic hit_set;  // last step of a multi-step command ended on the limit with no change
		logic out_load; // copy result into the output register
	} ctrl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic changed;  // plane part after this step differs from its value at accept
		logic at_limit; // this step reaches the step limit
	} stat_t;

endpackage

FILE: hw/rtl/grid_ray_stepper.sv
// grid_ray_stepper: top level, joins the sequencer and the datapath.
// Depends on grs_pkg, grs_ctrl, grs_dpath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  input    | in_valid/in_stall  | cmd, pos_x/y/z, angle, plane_mode, entry_x/y/z
//  result   | out_valid/out_stall| cur_x/y/z, origin_x/y/z, steps_taken, limit_hit
//  config   | cfg_we             | cfg_index, cfg_data
//
// Start, extend, load and unused codes go straight from accept to the result state.
// Step commands read the table at the accept edge, then do one 32-bit add and plane
// compare per step cycle in the step state, then go through the same result state.
// One command is in flight at a time; the next is taken once the result sits in
// the output register, which holds while out_stall is high.
// Reset clears the ray to the origin in XY mode; the direction table is not cleared.
module grid_ray_stepper #(
	parameter int ANGLE_COUNT   = 256,
	parameter int FRACTION_BITS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [7:0]         angle,
	input  logic [1:0]         plane_mode,
	input  logic signed [31:0] entry_x,
	input  logic signed [31:0] entry_y,
	input  logic signed [31:0] entry_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] cur_x,
	output logic signed [31:0] cur_y,
	output logic signed [31:0] cur_z,
	output logic signed [31:0] origin_x,
	output logic signed [31:0] origin_y,
	output logic signed [31:0] origin_z,
	output logic [15:0]        steps_taken,
	output logic               limit_hit,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);

	grs_pkg::ctrl_t ctrl;
	grs_pkg::stat_t stat;

	grs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	grs_dpath #(
		.ANGLE_COUNT   (ANGLE_COUNT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.angle      (angle),
		.plane_mode (plane_mode),
		.entry_x    (entry_x),
		.entry_y    (entry_y),
		.entry_z    (entry_z),
		.res_cur_x  (cur_x),
		.res_cur_y  (cur_y),
		.res_cur_z  (cur_z),
		.res_org_x  (origin_x),
		.res_org_y  (origin_y),
		.res_org_z  (origin_z),
		.res_steps  (steps_taken),
		.res_hit    (limit_hit)
	);

endmodule

FILE: hw/rtl/grs_ctrl.sv
// grs_ctrl: command sequencer of the grid ray stepper.
// Depends on grs_pkg (cmd_t, ctrl_t, stat_t).
module grs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [2:0]      cmd,
	output logic            out_valid,
	input  logic            out_stall,
	output grs_pkg::ctrl_t  ctrl,
	input  grs_pkg::stat_t  stat
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_STEP   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t state_q;
	logic   single_q;
	logic   out_valid_q;
	logic   accept;
	logic   is_step_cmd;
	logic   stop;
	logic   out_load;

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid && !in_stall;
	assign is_step_cmd = (cmd == grs_pkg::CMD_STEP) || (cmd == grs_pkg::CMD_UNIT) ||
		(cmd == grs_pkg::CMD_TILE);
	assign stop        = single_q || stat.changed || stat.at_limit;
	assign out_load    = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);
	assign out_valid   = out_valid_q;

	// Drive datapath commands
	always_comb begin
		ctrl.accept   = accept;
		ctrl.step_en  = (state_q == ST_STEP);
		ctrl.hit_set  = (state_q == ST_STEP) && !single_q && !stat.changed && stat.at_limit;
		ctrl.out_load = out_load;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			single_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						single_q <= (cmd == grs_pkg::CMD_STEP);
						state_q  <= is_step_cmd ? ST_STEP : ST_RESULT;
					end
				end
				ST_STEP: begin
					if (stop) state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step_en && stat.at_limit) |=> !ctrl.step_en)
		else $error("stepping continued past the step limit");

	a_plain_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !is_step_cmd) |=> (state_q == ST_RESULT))
		else $error("non-step command did not go straight to result");

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RESULT))
		else $error("result beat raised outside result state");

	a_single_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step_en && single_q) |=> (state_q == ST_RESULT))
		else $error("single step took more than one step");

endmodule

FILE: hw/rtl/grs_dpath.sv
// grs_dpath: ray state, direction table memory, step adder and plane compare.
// Depends on grs_pkg (cmd_t, ctrl_t, stat_t, config codes).
module grs_dpath #(
	parameter int ANGLE_COUNT   = 256,
	parameter int FRACTION_BITS = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  grs_pkg::ctrl_t      ctrl,
	output grs_pkg::stat_t      stat,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic [2:0]          cmd,
	input  logic [31:0]         pos_x,
	input  logic [31:0]         pos_y,
	input  logic [31:0]         pos_z,
	input  logic [7:0]          angle,
	input  logic [1:0]          plane_mode,
	input  logic [31:0]         entry_x,
	input  logic [31:0]         entry_y,
	input  logic [31:0]         entry_z,
	output logic [31:0]         res_cur_x,
	output logic [31:0]         res_cur_y,
	output logic [31:0]         res_cur_z,
	output logic [31:0]         res_org_x,
	output logic [31:0]         res_org_y,
	output logic [31:0]         res_org_z,
	output logic [15:0]         res_steps,
	output logic                res_hit
);

	localparam int IDXW      = $clog2(ANGLE_COUNT);
	localparam int POS_SHIFT = FRACTION_BITS - 4;

	// Angle wrap table, worked out at elaboration
	logic [IDXW-1:0] angle_mod [256];
	for (genvar g = 0; g < 256; g++) begin : g_mod
		assign angle_mod[g] = IDXW'(g % ANGLE_COUNT);
	end

	logic [95:0]     dir_mem [ANGLE_COUNT];
	logic [95:0]     ofs_q;
	logic [31:0]     cur_q [3];
	logic [31:0]     org_q [3];
	logic [IDXW-1:0] angle_q;
	logic [1:0]      mode_q;
	logic [3:0]      tile_shift_q;
	logic [15:0]     step_limit_q;
	logic [31:0]     mask_q;
	logic [31:0]     base_a_q;
	logic [31:0]     base_b_q;
	logic [15:0]     steps_q;
	logic            hit_q;
	logic [31:0]     out_cur_q [3];
	logic [31:0]     out_org_q [3];
	logic [15:0]     out_steps_q;
	logic            out_hit_q;

	logic [IDXW-1:0] in_idx;
	logic            is_step_cmd;
	logic [5:0]      sh_full;
	logic [4:0]      sh_clamp;
	logic [31:0]     ofs [3];
	logic [31:0]     cur_nxt [3];
	logic [31:0]     a_now;
	logic [31:0]     b_now;
	logic [31:0]     a_nxt;
	logic [31:0]     b_nxt;
	logic [15:0]     steps_inc;
	logic [15:0]     lim;

	assign in_idx      = angle_mod[angle];
	assign is_step_cmd = (cmd == grs_pkg::CMD_STEP) || (cmd == grs_pkg::CMD_UNIT) ||
		(cmd == grs_pkg::CMD_TILE);

	// Plane compare shift: whole unit or tile, clamp to sign-only
	assign sh_full  = 6'(FRACTION_BITS) +
		((cmd == grs_pkg::CMD_TILE) ? {2'b00, tile_shift_q} : 6'd0);
	assign sh_clamp = (sh_full > 6'd31) ? 5'd31 : sh_full[4:0];

	// Remap table offsets for the plane mode
	always_comb begin
		case (mode_q)
			2'd1: begin
				ofs[0] = ofs_q[31:0];
				ofs[1] = 32'd0;
				ofs[2] = ofs_q[63:32];
			end
			2'd2: begin
				ofs[0] = 32'd0;
				ofs[1] = ofs_q[63:32];
				ofs[2] = ofs_q[31:0];
			end
			default: begin
				ofs[0] = ofs_q[31:0];
				ofs[1] = ofs_q[63:32];
				ofs[2] = ofs_q[95:64];
			end
		endcase
	end

	// Step adders and plane axis selection
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur_nxt[i] = cur_q[i] + ofs[i];
		end
		case (mode_q)
			2'd1: begin
				a_now = cur_q[0];   b_now = cur_q[2];
				a_nxt = cur_nxt[0]; b_nxt = cur_nxt[2];
			end
			2'd2: begin
				a_now = cur_q[1];   b_now = cur_q[2];
				a_nxt = cur_nxt[1]; b_nxt = cur_nxt[2];
			end
			default: begin
				a_now = cur_q[0];   b_now = cur_q[1];
				a_nxt = cur_nxt[0]; b_nxt = cur_nxt[1];
			end
		endcase
	end

	assign steps_inc     = steps_q + 16'd1;
	assign lim           = (step_limit_q == 16'd0) ? 16'd1 : step_limit_q;
	assign stat.changed  = |(((a_nxt ^ base_a_q) | (b_nxt ^ base_b_q)) & mask_q);
	assign stat.at_limit = (steps_inc == lim);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_shift_q <= grs_pkg::TILE_SHIFT_RST;
			step_limit_q <= grs_pkg::STEP_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				grs_pkg::CFG_TILE_SHIFT: tile_shift_q <= cfg_data[3:0];
				grs_pkg::CFG_STEP_LIMIT: step_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Direction table: write on load, registered read on step commands
	always_ff @(posedge clk) begin
		if (ctrl.accept && cmd == grs_pkg::CMD_LOAD) begin
			dir_mem[in_idx] <= {entry_z, entry_y, entry_x};
		end
		if (ctrl.accept && is_step_cmd) begin
			ofs_q <= dir_mem[angle_q];
		end
	end

	// Ray state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				cur_q[i] <= 32'd0;
				org_q[i] <= 32'd0;
			end
			angle_q <= '0;
			mode_q  <= 2'd0;
		end else if (ctrl.accept && cmd == grs_pkg::CMD_START) begin
			cur_q[0] <= pos_x << POS_SHIFT;
			cur_q[1] <= pos_y << POS_SHIFT;
			cur_q[2] <= pos_z << POS_SHIFT;
			org_q[0] <= pos_x << POS_SHIFT;
			org_q[1] <= pos_y << POS_SHIFT;
			org_q[2] <= pos_z << POS_SHIFT;
			angle_q  <= in_idx;
			mode_q   <= plane_mode;
		end else if (ctrl.accept && cmd == grs_pkg::CMD_EXTEND) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= cur_q[i];
			end
			angle_q <= in_idx;
		end else if (ctrl.step_en) begin
			for (int i = 0; i < 3; i++) begin
				cur_q[i] <= cur_nxt[i];
			end
		end
	end

	// Per-command plane baseline and compare mask
	always_ff @(posedge clk) begin
		if (ctrl.accept && is_step_cmd) begin
			mask_q   <= 32'hFFFF_FFFF << sh_clamp;
			base_a_q <= a_now;
			base_b_q <= b_now;
		end
	end

	// Step count and limit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= 16'd0;
			hit_q   <= 1'b0;
		end else if (ctrl.accept) begin
			steps_q <= 16'd0;
			hit_q   <= 1'b0;
		end else if (ctrl.step_en) begin
			steps_q <= steps_inc;
			if (ctrl.hit_set) hit_q <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			for (int i = 0; i < 3; i++) begin
				out_cur_q[i] <= cur_q[i];
				out_org_q[i] <= org_q[i];
			end
			out_steps_q <= steps_q;
			out_hit_q   <= hit_q;
		end
	end

	assign res_cur_x = out_cur_q[0];
	assign res_cur_y = out_cur_q[1];
	assign res_cur_z = out_cur_q[2];
	assign res_org_x = out_org_q[0];
	assign res_org_y = out_org_q[1];
	assign res_org_z = out_org_q[2];
	assign res_steps = out_steps_q;
	assign res_hit   = out_hit_q;

	a_steps_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step_en |-> (steps_q < lim))
		else $error("step count reached the limit while still stepping");

	a_hit_only_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.hit_set |-> (stat.at_limit && !stat.changed))
		else $error("limit flag set on a changed step");

	a_shape_held: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.step_en |=> $stable(mode_q) && $stable(angle_q))
		else $error("ray direction changed during stepping");

endmodule
